// ----- sv/lkpc_pkg.sv -----
// Package for the lamp key and proximity controller: codes, defaults and shared types.
package lkpc_pkg;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_HALF   = 2'd1;
  localparam logic [1:0] MODE_FULL   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] STEP_IDLE    = 3'd0;
  localparam logic [2:0] STEP_QUIET   = 3'd1;
  localparam logic [2:0] STEP_RISING  = 3'd2;
  localparam logic [2:0] STEP_HOLD    = 3'd3;
  localparam logic [2:0] STEP_RELEASE = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_MS        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IR_QUIET_MS     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IR_DETECT_LEVEL = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_IR_ABORT_LEVEL  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_IR_RISE_STEP    = 3'd6;

  localparam logic [7:0]  DEF_DEBOUNCE_MS     = 8'd35;
  localparam logic [15:0] DEF_LONG_PRESS_MS   = 16'd2000;
  localparam logic [15:0] DEF_SLEEP_MS        = 16'd5000;
  localparam logic [7:0]  DEF_IR_QUIET_MS     = 8'd20;
  localparam logic [9:0]  DEF_IR_DETECT_LEVEL = 10'd30;
  localparam logic [9:0]  DEF_IR_ABORT_LEVEL  = 10'd200;
  localparam logic [3:0]  DEF_IR_RISE_STEP    = 4'd5;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] sleep_ms;
    logic [7:0]  ir_quiet_ms;
    logic [9:0]  ir_detect_level;
    logic [9:0]  ir_abort_level;
    logic [3:0]  ir_rise_step;
  } cfg_t;

  typedef struct packed {
    logic        stable_key;
    logic [7:0]  debounce_count;
    logic        key_held;
    logic        key_edge;
    logic        press_pending;
    logic [15:0] press_count;
    logic [1:0]  lamp_mode;
    logic [1:0]  saved_mode;
    logic        sensing_on;
    logic [2:0]  gesture_step;
    logic [15:0] gesture_score;
    logic [15:0] idle_count;
  } state_t;

  typedef struct packed {
    logic [1:0] lamp_level;
    logic       emitter_on;
    logic       sleep_request;
  } result_t;

endpackage

// ----- sv/lamp_key_and_proximity_controller.sv -----
// Top level of the lamp key and proximity controller: handshakes, settings and result register.
// A request is held in the input stage and moves into the result register once that is free.
// Throughput: one request per cycle; a result left waiting holds the request in the input stage.
// The core state is updated by the per-tick logic between those registers.
// Synchronous active-high reset clears the core state, empties both stages and loads the
// default settings.
module lamp_key_and_proximity_controller import lkpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   key_level,
  input  logic                   ir_level,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             lamp_level,
  output logic                   emitter_on,
  output logic                   sleep_request,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t result;
  logic    s1_valid;
  logic    s1_key;
  logic    s1_ir;
  logic    advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEF_DEBOUNCE_MS;
      cfg.long_press_ms   <= DEF_LONG_PRESS_MS;
      cfg.sleep_ms        <= DEF_SLEEP_MS;
      cfg.ir_quiet_ms     <= DEF_IR_QUIET_MS;
      cfg.ir_detect_level <= DEF_IR_DETECT_LEVEL;
      cfg.ir_abort_level  <= DEF_IR_ABORT_LEVEL;
      cfg.ir_rise_step    <= DEF_IR_RISE_STEP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:     cfg.debounce_ms     <= cfg_data[7:0];
        REG_LONG_PRESS_MS:   cfg.long_press_ms   <= cfg_data;
        REG_SLEEP_MS:        cfg.sleep_ms        <= cfg_data;
        REG_IR_QUIET_MS:     cfg.ir_quiet_ms     <= cfg_data[7:0];
        REG_IR_DETECT_LEVEL: cfg.ir_detect_level <= cfg_data[9:0];
        REG_IR_ABORT_LEVEL:  cfg.ir_abort_level  <= cfg_data[9:0];
        REG_IR_RISE_STEP:    cfg.ir_rise_step    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key <= key_level;
      s1_ir  <= ir_level;
    end
  end

  lkpc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (advance),
    .key     (s1_key),
    .ir      (s1_ir),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lamp_level    <= result.lamp_level;
      emitter_on    <= result.emitter_on;
      sleep_request <= result.sleep_request;
    end
  end

  // A free result slot always lets the input stage take a new request.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stage stalled with a free result slot");

  // A request in the input stage reaches the result register when it may move.
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed request did not reach the result register");

  // The lamp drive never carries the unused code.
  a_lamp_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lamp_level != MODE_UNUSED))
    else $error("lamp drive holds an unused code");

  // Without a new request the result register empties once its result is taken.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !s1_valid) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

// ----- sv/lkpc_core.sv -----
// Controller state and the per-tick update of key, lamp, gesture and idle logic.
module lkpc_core import lkpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step_en,
  input  logic    key,
  input  logic    ir,
  output result_t result
);

  state_t st;
  state_t st_next;

  always_comb begin
    logic [8:0]  dcount;
    logic [16:0] pcount;
    logic [16:0] icount;
    logic [16:0] gsum;
    logic        pressed;
    logic        sleep_req;
    logic        gesture_live;

    st_next   = st;
    dcount    = {1'b0, st.debounce_count} + 9'd1;
    pcount    = {1'b0, st.press_count};
    icount    = {1'b0, st.idle_count} + 17'd1;
    gsum      = '0;
    pressed   = 1'b0;
    sleep_req = 1'b0;

    if (st.press_pending) begin
      pcount = {1'b0, st.press_count} + 17'd1;
    end
    if (icount > {1'b0, cfg.sleep_ms}) begin
      icount    = '0;
      sleep_req = 1'b1;
    end

    if (key != st.stable_key) begin
      if (dcount > {1'b0, cfg.debounce_ms}) begin
        st_next.stable_key = key;
        dcount = '0;
      end
    end else begin
      pressed = ~st.stable_key;
      dcount = '0;
      st_next.key_edge = pressed & (pressed ^ st.key_held);
      st_next.key_held = pressed;
    end
    st_next.debounce_count = dcount[8] ? 8'hFF : dcount[7:0];

    if (st_next.key_held && st_next.key_edge) begin
      st_next.press_pending = 1'b1;
    end
    if (!st_next.key_held) begin
      pcount = '0;
      if (st_next.press_pending) begin
        st_next.press_pending = 1'b0;
        priority if (st.lamp_mode == MODE_HALF) begin
          st_next.lamp_mode = MODE_FULL;
        end else if (st.lamp_mode == MODE_FULL) begin
          st_next.lamp_mode = MODE_OFF;
        end else if (st.saved_mode == MODE_OFF) begin
          st_next.lamp_mode = MODE_HALF;
        end else begin
          st_next.lamp_mode = (st.saved_mode == MODE_HALF) ? MODE_FULL : MODE_HALF;
          st_next.saved_mode = MODE_OFF;
        end
      end
    end
    if (pcount > {1'b0, cfg.long_press_ms}) begin
      st_next.press_pending = 1'b0;
      pcount = '0;
      st_next.gesture_step = STEP_QUIET;
      st_next.gesture_score = '0;
      st_next.sensing_on = ~st.sensing_on;
    end
    st_next.press_count = pcount[16] ? 16'hFFFF : pcount[15:0];

    gesture_live = st_next.sensing_on &&
                   !(st_next.lamp_mode == MODE_OFF && st_next.saved_mode == MODE_OFF);
    if (gesture_live) begin
      unique case (st_next.gesture_step)
        STEP_QUIET: begin
          if (ir) begin
            gsum = {1'b0, st_next.gesture_score} + 17'd1;
            st_next.gesture_score = gsum[16] ? 16'hFFFF : gsum[15:0];
          end else begin
            if (st_next.gesture_score > {8'd0, cfg.ir_quiet_ms}) begin
              st_next.gesture_step = STEP_RISING;
            end
            st_next.gesture_score = '0;
          end
        end
        STEP_RISING: begin
          if (!ir) begin
            gsum = {1'b0, st_next.gesture_score} + {13'd0, cfg.ir_rise_step};
            st_next.gesture_score = gsum[16] ? 16'hFFFF : gsum[15:0];
          end else if (st_next.gesture_score != '0) begin
            st_next.gesture_score = st_next.gesture_score - 16'd1;
          end else begin
            st_next.gesture_step = STEP_QUIET;
          end
          if (st_next.gesture_score > {6'd0, cfg.ir_detect_level}) begin
            st_next.gesture_step = STEP_HOLD;
          end
        end
        STEP_HOLD: begin
          if (!ir) begin
            gsum = {1'b0, st_next.gesture_score} + 17'd1;
            st_next.gesture_score = gsum[16] ? 16'hFFFF : gsum[15:0];
          end else if (st_next.gesture_score != '0) begin
            st_next.gesture_score = st_next.gesture_score - 16'd1;
          end else begin
            st_next.gesture_step = STEP_RELEASE;
          end
          if (st_next.gesture_score > {6'd0, cfg.ir_abort_level}) begin
            st_next.gesture_score = '0;
            st_next.gesture_step = STEP_QUIET;
          end
        end
        STEP_RELEASE: begin
          st_next.gesture_step = STEP_QUIET;
          if (st_next.saved_mode == MODE_OFF) begin
            st_next.saved_mode = st_next.lamp_mode;
            st_next.lamp_mode = MODE_OFF;
          end else begin
            st_next.lamp_mode = st_next.saved_mode;
            st_next.saved_mode = MODE_OFF;
          end
        end
        default: begin
        end
      endcase
    end

    if (st_next.lamp_mode != MODE_OFF || st_next.sensing_on) begin
      st_next.idle_count = '0;
    end else begin
      st_next.idle_count = icount[15:0];
    end

    result.lamp_level = (st_next.lamp_mode == MODE_UNUSED) ? MODE_OFF : st_next.lamp_mode;
    result.emitter_on = st_next.sensing_on;
    result.sleep_request = sleep_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_en) begin
      st <= st_next;
    end
  end

endmodule
